FILE: design/polyphase_fir_rate_converter_defines.svh
// Assertion macros shared by the polyphase FIR rate converter RTL.
`ifndef POLYPHASE_FIR_RATE_CONVERTER_DEFINES_SVH
`define POLYPHASE_FIR_RATE_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PFRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PFRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pfrc_pkg.sv
// Package with the types, constants and codes of the polyphase FIR rate converter.
package pfrc_pkg;

    localparam int MAX_TAPS   = 16;
    localparam int ACC_BITS   = 40;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int SCALED_W   = ACC_BITS + 2;
    localparam int FRAC_BITS  = 15;
    localparam int QUOT_W     = SCALED_W - FRAC_BITS;

    localparam int NCOEF      = 16;
    localparam int NWORDS     = 4;
    localparam int COEF_PER_W = NCOEF / NWORDS;
    localparam int COEF_IDX_W = $clog2(NCOEF);

    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int CNT_W      = $clog2(MAX_TAPS) + 2;
    localparam int TAPCNT_W   = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF3 = 3'd5;

    // Mode codes.
    localparam logic [2:0] MODE_FIR  = 3'd0;
    localparam logic [2:0] MODE_DEC2 = 3'd1;
    localparam logic [2:0] MODE_DEC3 = 3'd2;
    localparam logic [2:0] MODE_INT2 = 3'd3;
    localparam logic [2:0] MODE_INT3 = 3'd4;

    localparam logic [1:0] GAIN_ONE = 2'd1;
    localparam logic [1:0] GAIN_TWO = 2'd2;
    localparam logic [1:0] GAIN_THREE = 2'd3;

    typedef logic [NCOEF-1:0][COEF_W-1:0] pfrc_coefs_t;

    typedef struct packed {
        logic       decim;
        logic       interp;
        logic [1:0] factor;
    } pfrc_mode_t;

    typedef struct packed {
        logic                  shift;
        logic                  acc_clear;
        logic                  mac_en;
        logic                  scale;
        logic                  load_out;
        logic                  last;
        logic [COEF_IDX_W-1:0] coef_idx;
        logic [TAP_W-1:0]      age;
        logic [1:0]            gain;
    } pfrc_cmd_t;

    typedef struct packed {
        logic out_free;
    } pfrc_stat_t;

endpackage

FILE: design/pfrc_cfg.sv
// Configuration registers and mode decode of the polyphase FIR rate converter.
module pfrc_cfg
    import pfrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output pfrc_mode_t            mode,
    output logic                  mode_wr,
    output logic [CNT_W-1:0]      taps,
    output pfrc_coefs_t           coefs
);

    logic [2:0]            mode_reg;
    logic [TAPCNT_W-1:0]   tap_count_reg;
    logic [CFG_DATA_W-1:0] coef_word_reg [NWORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_FIR;
            tap_count_reg <= TAPCNT_W'(15);
            for (int k = 0; k < NWORDS; k++)
            begin
                coef_word_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg         <= cfg_data[2:0];
                REG_TAPS:  tap_count_reg    <= cfg_data[TAPCNT_W-1:0];
                REG_COEF0: coef_word_reg[0] <= cfg_data;
                REG_COEF1: coef_word_reg[1] <= cfg_data;
                REG_COEF2: coef_word_reg[2] <= cfg_data;
                REG_COEF3: coef_word_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign mode_wr = cfg_we && (cfg_index == REG_MODE);

    // A tap count of zero acts as one; counts above the line length saturate.
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps = CNT_W'(1);
        end
        else if (32'(tap_count_reg) > MAX_TAPS)
        begin
            taps = CNT_W'(MAX_TAPS);
        end
        else
        begin
            taps = CNT_W'(tap_count_reg);
        end
    end

    // Unused mode codes fall back to the plain filter.
    always_comb
    begin
        unique case (mode_reg)
            MODE_DEC2: mode = '{decim: 1'b1, interp: 1'b0, factor: 2'd2};
            MODE_DEC3: mode = '{decim: 1'b1, interp: 1'b0, factor: 2'd3};
            MODE_INT2: mode = '{decim: 1'b0, interp: 1'b1, factor: 2'd2};
            MODE_INT3: mode = '{decim: 1'b0, interp: 1'b1, factor: 2'd3};
            default:   mode = '{decim: 1'b0, interp: 1'b0, factor: 2'd1};
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < NWORDS; k++)
        begin
            for (int j = 0; j < COEF_PER_W; j++)
            begin
                coefs[k*COEF_PER_W + j] = coef_word_reg[k][j*COEF_W +: COEF_W];
            end
        end
    end

endmodule

FILE: design/pfrc_ctrl.sv
// Controller state machine that sequences taps, phases and output transfers.
module pfrc_ctrl
    import pfrc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  pfrc_mode_t       mode,
    input  logic             mode_wr,
    input  logic [CNT_W-1:0] taps,
    input  pfrc_stat_t       stat,
    output pfrc_cmd_t        cmd
);

`include "polyphase_fir_rate_converter_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_SCALE,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] c_reg, c_next;
    logic [TAP_W-1:0] a_reg, a_next;
    logic [1:0]       p_reg, p_next;
    logic [1:0]       phase_reg, phase_next;

    logic             start;
    logic [1:0]       start_p;
    logic [CNT_W-1:0] step;
    logic [2:0]       phase_sum;
    logic             last_phase;

    assign step       = mode.interp ? CNT_W'(mode.factor) : CNT_W'(1);
    assign phase_sum  = {1'b0, phase_reg} + 3'd1;
    assign last_phase = !mode.interp || (p_reg == (mode.factor - 2'd1));
    assign in_stall   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        a_next     = a_reg;
        p_next     = p_reg;
        phase_next = phase_reg;
        start      = 1'b0;
        start_p    = 2'd0;
        cmd        = '0;
        cmd.coef_idx = c_reg[COEF_IDX_W-1:0];
        cmd.age      = a_reg;
        cmd.gain     = mode.interp ? mode.factor : GAIN_ONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.shift = 1'b1;
                    if (mode.decim)
                    begin
                        start      = (phase_reg == 2'd0);
                        phase_next = (phase_sum >= {1'b0, mode.factor}) ? 2'd0 : phase_sum[1:0];
                    end
                    else
                    begin
                        start = 1'b1;
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac_en = 1'b1;
                if ((c_reg + step) >= taps)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    c_next = c_reg + step;
                    a_next = mode.interp ? a_reg + 1'b1 : a_reg - 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.last     = last_phase;
                    if (last_phase)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        start   = 1'b1;
                        start_p = p_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Phase p of an interpolator starts at coefficient p and the newest sample;
        // the plain filter starts at coefficient 0 and the oldest sample in use.
        if (start)
        begin
            cmd.acc_clear = 1'b1;
            p_next        = start_p;
            c_next        = mode.interp ? CNT_W'(start_p) : '0;
            a_next        = mode.interp ? '0 : TAP_W'(taps - CNT_W'(1));
            state_next    = (c_next >= taps) ? S_DRAIN : S_MAC;
        end

        if (mode_wr)
        begin
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            c_reg     <= '0;
            a_reg     <= '0;
            p_reg     <= 2'd0;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            a_reg     <= a_next;
            p_reg     <= p_next;
            phase_reg <= phase_next;
        end
    end

    `PFRC_ASSERT_IMP(a_mac_in_range, state_reg == S_MAC, c_reg < taps,
        "tap counter beyond tap count")
    `PFRC_ASSERT_IMP(a_phase_legal, 1'b1, phase_reg != 2'd3,
        "decimation phase out of range")
    `PFRC_ASSERT_NXT(a_emit_holds, (state_reg == S_EMIT) && !stat.out_free,
        (state_reg == S_EMIT) && $stable(p_reg), "emit state left while output busy")

endmodule

FILE: design/pfrc_dp.sv
// Datapath with delay line, multiply-accumulate, scaling, saturation and output register.
module pfrc_dp
    import pfrc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  pfrc_cmd_t           cmd,
    input  pfrc_coefs_t         coefs,
    input  logic                out_stall,
    output pfrc_stat_t          stat,
    output logic                out_valid,
    output logic [SAMPLE_W-1:0] sample_out,
    output logic                last_of_run
);

`include "polyphase_fir_rate_converter_defines.svh"

    logic signed [SAMPLE_W-1:0] dl_reg [MAX_TAPS];
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       prod_vld_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [SCALED_W-1:0] scaled_reg, scaled_next;
    logic signed [SCALED_W-1:0] acc_ext;
    logic signed [QUOT_W-1:0]   quot;
    logic [SAMPLE_W-1:0]        sat_next;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        sample_out_reg;
    logic                       last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                dl_reg[i] <= '0;
            end
        end
        else if (cmd.shift)
        begin
            dl_reg[0] <= sample_in;
            for (int i = 1; i < MAX_TAPS; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    assign prod_next = $signed(coefs[cmd.coef_idx]) * dl_reg[cmd.age];

    // The product is registered and added in the following cycle; the sum wraps at ACC_BITS.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= cmd.mac_en;
            if (cmd.acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_BITS'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.scale)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign acc_ext = SCALED_W'(acc_reg);

    always_comb
    begin
        unique case (cmd.gain)
            GAIN_TWO:   scaled_next = acc_ext <<< 1;
            GAIN_THREE: scaled_next = acc_ext + (acc_ext <<< 1);
            default:    scaled_next = acc_ext;
        endcase
    end

    // Arithmetic shift rounds toward minus infinity; then clamp to 16 bits.
    assign quot = QUOT_W'(scaled_reg >>> FRAC_BITS);

    always_comb
    begin
        if ((&quot[QUOT_W-1:SAMPLE_W-1]) || !(|quot[QUOT_W-1:SAMPLE_W-1]))
        begin
            sat_next = quot[SAMPLE_W-1:0];
        end
        else if (quot[QUOT_W-1])
        begin
            sat_next = SAMPLE_MIN;
        end
        else
        begin
            sat_next = SAMPLE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_out_reg <= sat_next;
            last_reg       <= cmd.last;
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;
    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign last_of_run   = last_reg;

    `PFRC_ASSERT_IMP(a_load_when_free, cmd.load_out, !out_valid_reg || !out_stall,
        "output register overwritten while a transfer is pending")

endmodule

FILE: design/polyphase_fir_rate_converter.sv
// Top level of the polyphase FIR rate converter: configuration, controller and datapath.
//
// Input channel: in_valid, in_stall and sample_in; a transfer happens at a clock edge
// with in_valid high and in_stall low. The block takes one sample at a time and keeps
// in_stall high from the transfer until all of that sample's results are loaded.
// Output channel: out_valid, out_stall, sample_out and last_of_run, driven from an
// output register; last_of_run marks the final result of one input sample.
// One shared 16x16 multiplier handles one tap per cycle, followed by a product
// register, so a phase runs through its taps, a drain step, a scale step and a load step.
// Plain and decimating modes: the block takes no new sample until the result of the
// last one is loaded, and a dropped decimation sample starts no run. Interpolation
// by L over T taps: phase p covers ceil((T - p) / L) taps; phases run back to back.
// When out_stall holds a result, the finished phase waits in its load step and the
// next phase starts only once that result is loaded; in_stall stays high meanwhile.
// Reset clears the delay line, decimation phase, controller state and configuration
// registers (mode 0, 15 taps, zero coefficients). Configuration writes through cfg_we,
// cfg_index and cfg_data take effect at once and are meant for idle periods; writing
// mode restarts the decimation phase.
module polyphase_fir_rate_converter
    import pfrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SAMPLE_W-1:0]   sample_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SAMPLE_W-1:0]   sample_out,
    output logic                  last_of_run
);

    pfrc_mode_t       mode;
    logic             mode_wr;
    logic [CNT_W-1:0] taps;
    pfrc_coefs_t      coefs;
    pfrc_cmd_t        cmd;
    pfrc_stat_t       stat;

    // Register file; the user must change it only between samples, which the block does not enforce.
    pfrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .mode_wr   (mode_wr),
        .taps      (taps),
        .coefs     (coefs)
    );

    // Sequencer for taps and phases.
    pfrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .mode_wr  (mode_wr),
        .taps     (taps),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Delay line, accumulator and output register.
    pfrc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_in   (sample_in),
        .cmd         (cmd),
        .coefs       (coefs),
        .out_stall   (out_stall),
        .stat        (stat),
        .out_valid   (out_valid),
        .sample_out  (sample_out),
        .last_of_run (last_of_run)
    );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the polyphase FIR rate converter: stimulus, prediction, checks.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfrc_pkg::*;

    // Register indexes that map to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
    // Highest mode code; the spare codes behave like the plain filter.
    localparam logic [2:0] MODE_SPARE = 3'd7;

    localparam int RANDOM_ITEMS   = 100;
    // The block needs less than this pause for one plain or interpolate-by-3 sample,
    // so this pause covers any work still in flight.
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 240;
    // Longest quiet stretch of a correct run is the receiver hold-off above plus
    // a long random gap and the block latency; this limit is several times that.
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } fir_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample_in = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SAMPLE_W-1:0]   sample_out;
    logic                  last_of_run;

    // Samples waiting to be offered, and filter outputs still owed by the block.
    logic [SAMPLE_W-1:0] sample_q [$];
    fir_result_t         filtered_q [$];

    // Shadow copy of the block state and registers, updated on every transfer
    // and register write seen at the clock edge.
    logic signed [SAMPLE_W-1:0] history [MAX_TAPS] = '{default: '0};
    logic [CFG_DATA_W-1:0]      coef_words [NWORDS] = '{default: '0};
    logic [2:0]                 cur_mode = MODE_FIR;
    logic [TAPCNT_W-1:0]        cur_taps = 5'd15;
    logic [1:0]                 dec_phase = 2'd0;

    int  samples_queued = 0;
    int  samples_taken = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    bit  calm = 1'b0;
    bit  in_took = 1'b0;

    polyphase_fir_rate_converter u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .last_of_run (last_of_run)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_at(input int c);
        return coef_words[c / COEF_PER_W][(c % COEF_PER_W) * COEF_W +: COEF_W];
    endfunction

    // A tap count of zero acts as one tap; anything above the line depth is clipped.
    function automatic int taps_active();
        if (cur_taps == 0)
            return 1;
        if (cur_taps > MAX_TAPS)
            return MAX_TAPS;
        return cur_taps;
    endfunction

    // Multiply by the rate factor, floor-shift by 15 and clamp to 16 bits.
    function automatic logic [SAMPLE_W-1:0] scale_sat(input logic signed [ACC_BITS-1:0] acc,
                                                      input int fold);
        longint v;
        v = longint'(acc) * fold;
        v = v >>> FRAC_BITS;
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[SAMPLE_W-1:0];
    endfunction

    // Plain form: coefficient j weights the sample that is (T-1-j) items old.
    // The sum is kept at accumulator width, so it wraps the way the hardware does.
    function automatic logic [SAMPLE_W-1:0] direct_form(input int taps);
        logic signed [ACC_BITS-1:0] acc;
        acc = '0;
        for (int j = 0; j < taps; j++)
            acc = acc + coef_at(j) * history[taps - 1 - j];
        return scale_sat(acc, 1);
    endfunction

    // Polyphase form: phase p uses coefficients p, p+L, p+2L, ... on ages 0, 1, 2, ...
    function automatic logic [SAMPLE_W-1:0] phase_form(input int taps, input int p,
                                                       input int fold);
        logic signed [ACC_BITS-1:0] acc;
        int age;
        acc = '0;
        age = 0;
        for (int c = p; c < taps; c += fold) begin
            acc = acc + coef_at(c) * history[age];
            age++;
        end
        return scale_sat(acc, fold);
    endfunction

    // Shifts one sample into the shadow delay line and queues the outputs it owes.
    task automatic filter_step(input logic [SAMPLE_W-1:0] s);
        int          taps;
        int          fold;
        fir_result_t r;
        for (int i = MAX_TAPS - 1; i > 0; i--)
            history[i] = history[i - 1];
        history[0] = s;
        taps = taps_active();
        case (cur_mode)
            MODE_DEC2, MODE_DEC3:
            begin
                fold = (cur_mode == MODE_DEC2) ? 2 : 3;
                if (dec_phase == 2'd0) begin
                    r.sample = direct_form(taps);
                    r.last = 1'b1;
                    filtered_q.push_back(r);
                end
                dec_phase = (dec_phase + 1 >= fold) ? 2'd0 : dec_phase + 2'd1;
            end
            MODE_INT2, MODE_INT3:
            begin
                fold = (cur_mode == MODE_INT2) ? 2 : 3;
                for (int p = 0; p < fold; p++) begin
                    r.sample = phase_form(taps, p, fold);
                    r.last = (p == fold - 1);
                    filtered_q.push_back(r);
                end
            end
            default:
            begin
                r.sample = direct_form(taps);
                r.last = 1'b1;
                filtered_q.push_back(r);
            end
        endcase
    endtask

    task automatic shadow_write(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MODE:
            begin
                cur_mode = data[2:0];
                dec_phase = 2'd0;
            end
            REG_TAPS:  cur_taps = data[TAPCNT_W-1:0];
            REG_COEF0: coef_words[0] = data;
            REG_COEF1: coef_words[1] = data;
            REG_COEF2: coef_words[2] = data;
            REG_COEF3: coef_words[3] = data;
            default:   ;
        endcase
    endtask

    // Observer at the rising edge. Values read here are the ones from before the
    // edge, so transfers are judged exactly as the block sees them. Outputs are
    // checked before the new input is predicted; a sample's own results can never
    // leave in the cycle it is taken.
    always @(posedge clk)
    begin : observer
        fir_result_t want;
        in_took = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected output: sample_out %0d last_of_run %0b",
                           $signed(sample_out), last_of_run);
                    mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (sample_out !== want.sample) begin
                        $error("sample_out: expected %0d, got %0d",
                               $signed(want.sample), $signed(sample_out));
                        mismatches++;
                    end
                    if (last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                filter_step(sample_in);
                samples_taken++;
                in_took = 1'b1;
            end
            if (cfg_we)
                shadow_write(cfg_index, cfg_data);
        end
        // Watchdog: any transfer or register write counts as progress.
        if (in_took || (rst_n && out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Sample sender. Once valid is up it stays up with the same payload until the
    // transfer happens; after each transfer it may idle for a random number of cycles.
    always @(negedge clk)
    begin : feeder
        if (rst_n && (!in_valid || in_took)) begin
            if (send_gap > 0) begin
                in_valid <= 1'b0;
                send_gap--;
            end else if (sample_q.size() != 0) begin
                in_valid  <= 1'b1;
                sample_in <= sample_q.pop_front();
                send_gap  = calm ? 0 : idle_len();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output receiver. Random stalls, plus one long hold-off on request so that
    // a result sits in the output register and the block backs up into its input.
    always @(negedge clk)
    begin : sink
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            stall_left = calm ? 0 : idle_len();
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        sample_q.push_back(s);
        samples_queued++;
    endtask

    // Waits until every queued sample has been taken and every owed output has
    // come out, then lets a dropped decimation sample finish inside the block.
    task automatic drain();
        while (samples_taken != samples_queued || filtered_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 4))
                0:       return SAMPLE_MIN;
                1:       return SAMPLE_MAX;
                2:       return 16'h0000;
                3:       return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        return SAMPLE_W'($urandom);
    endfunction

    // Random coefficients, usually scaled down so that sums do not always clip.
    function automatic logic [CFG_DATA_W-1:0] rand_coef_word();
        logic [CFG_DATA_W-1:0]      w;
        logic signed [COEF_W-1:0]   c;
        int                         sh;
        sh = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
        for (int k = 0; k < COEF_PER_W; k++) begin
            c = COEF_W'($urandom);
            w[k * COEF_W +: COEF_W] = c >>> sh;
        end
        return w;
    endfunction

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] mode_word;
        logic [CFG_DATA_W-1:0] taps_word;
        int                    random_sent;
        int                    phase_no;
        int                    n;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset defaults: plain filter, 15 taps, zero coefficients, so all zero out.
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        drain();

        // All coefficients at full positive scale over the whole line.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_FIR));
        write_reg(REG_TAPS, CFG_DATA_W'(16));
        write_reg(REG_COEF0, {4{16'h7FFF}});
        write_reg(REG_COEF1, {4{16'h7FFF}});
        write_reg(REG_COEF2, {4{16'h7FFF}});
        write_reg(REG_COEF3, {4{16'h7FFF}});
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(16'h0001);
        drain();

        // Most negative coefficients against most negative samples: positive clipping,
        // then a large positive sample swings toward the negative side.
        write_reg(REG_COEF0, {4{16'h8000}});
        write_reg(REG_COEF1, {4{16'h8000}});
        write_reg(REG_COEF2, {4{16'h8000}});
        write_reg(REG_COEF3, {4{16'h8000}});
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        drain();

        // Decimate by 2 with a single tap. Three samples leave the phase at one,
        // so the next mode write has a phase to clear.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_DEC2));
        write_reg(REG_TAPS, CFG_DATA_W'(1));
        write_reg(REG_COEF0, 64'h0000_0000_0000_4000);
        queue_sample(SAMPLE_MAX);
        queue_sample(16'h1234);
        queue_sample(SAMPLE_MIN);
        drain();

        // Decimate by 3 with a tap count of zero, which acts as one tap.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_DEC3));
        write_reg(REG_TAPS, CFG_DATA_W'(0));
        queue_sample(16'h7000);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        drain();

        // Interpolate by 2 over all taps with mixed-sign coefficients.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_INT2));
        write_reg(REG_TAPS, CFG_DATA_W'(16));
        write_reg(REG_COEF0, 64'h8000_7FFF_C000_2000);
        write_reg(REG_COEF1, 64'h7FFF_8000_2000_C000);
        write_reg(REG_COEF2, 64'h8000_8000_7FFF_7FFF);
        write_reg(REG_COEF3, 64'h0001_FFFF_8000_7FFF);
        queue_sample(SAMPLE_MAX);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MAX);
        drain();

        // Interpolate by 3 with a tap count beyond the line depth; gain 3 clips hard.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_INT3));
        write_reg(REG_TAPS, CFG_DATA_W'(31));
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN);
        drain();

        // Writes to the unused indexes change nothing; a spare mode code filters plainly.
        write_reg(REG_SPARE6, {$urandom, $urandom});
        write_reg(REG_SPARE7, {$urandom, $urandom});
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE));
        write_reg(REG_TAPS, CFG_DATA_W'(5));
        queue_sample(16'h4000);
        drain();

        // Random part: each phase picks a fresh setting, with junk in the unused
        // upper bits of the mode and tap count words. The first phase carries the
        // long receiver hold-off; the third runs with no idling on either side.
        random_sent = 0;
        phase_no = 0;
        while (random_sent < RANDOM_ITEMS) begin
            mode_word = {$urandom, $urandom};
            mode_word[2:0] = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                          : 3'($urandom_range(0, 4));
            taps_word = {$urandom, $urandom};
            taps_word[TAPCNT_W-1:0] = ($urandom_range(0, 7) == 0)
                                      ? TAPCNT_W'($urandom_range(0, 31))
                                      : TAPCNT_W'($urandom_range(1, 16));
            write_reg(REG_MODE, mode_word);
            write_reg(REG_TAPS, taps_word);
            for (int k = 0; k < NWORDS; k++)
                write_reg(CFG_IDX_W'(REG_COEF0 + k), rand_coef_word());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});

            calm = (phase_no == 2);
            n = $urandom_range(8, 24);
            for (int i = 0; i < n; i++)
                queue_sample(rand_sample());
            if (phase_no == 0)
                hold_req++;
            random_sent += n;
            phase_no++;
            drain();
            calm = 1'b0;
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/pfrc_pkg.sv
design/pfrc_cfg.sv
design/pfrc_ctrl.sv
design/pfrc_dp.sv
design/polyphase_fir_rate_converter.sv
dv/tb_top.sv
